// ===== rtl/molecule_center_of_mass_pbc_core_assert.svh =====
// Assertion macros for the molecule center of mass core.
// Included by the top level; no other dependencies.
`ifndef MOLECULE_CENTER_OF_MASS_PBC_CORE_ASSERT_SVH
`define MOLECULE_CENTER_OF_MASS_PBC_CORE_ASSERT_SVH
`ifndef SYNTH
`define MCOM_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MCOM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MCOM_ASSERT_IMPL(label, clk, rst, a, c)
`define MCOM_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/mcom_pkg.sv =====
// Shared types and constants for the molecule center of mass core.
// No dependencies.
package mcom_pkg;
  localparam int MaxAtoms = 128;
  localparam int QueueDepth = 2;

  // One finished molecule handed from the accumulator to the divider.
  typedef struct packed {
    logic [63:0] sum_x;
    logic [63:0] sum_y;
    logic [63:0] sum_z;
    logic [23:0] mass;
  } mol_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef enum logic [1:0] {
    REG_BOX_X = 2'd0,
    REG_BOX_Y = 2'd1,
    REG_BOX_Z = 2'd2,
    REG_ATOMS = 2'd3
  } reg_idx_t;
endpackage

// ===== rtl/mcom_front.sv =====
// Front end: minimum-image unwrap and mass-weighted accumulation.
// Depends on mcom_pkg.
module mcom_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       atom_x,
  input  logic [31:0]       atom_y,
  input  logic [31:0]       atom_z,
  input  logic [15:0]       atom_mass,
  input  logic [30:0]       box_x,
  input  logic [30:0]       box_y,
  input  logic [30:0]       box_z,
  input  logic [7:0]        atoms_per_molecule,
  output logic              mol_valid,
  input  logic              mol_ready,
  output mcom_pkg::mol_t    mol
);
  logic [31:0] prev [3];
  logic [39:0] unw [3];
  logic [63:0] wsum [3];
  logic [23:0] mass_sum;
  logic [7:0]  atom_counter;
  logic [7:0]  mol_size;

  // Stage registers between the fold and the multiply.
  logic        s1_valid;
  logic        s1_last;
  logic        s1_first;
  logic [39:0] s1_pos [3];
  logic [15:0] s1_mass;
  logic [23:0] s1_msum;

  logic [31:0] raw [3];
  logic [30:0] box [3];
  logic [39:0] unw_next [3];
  logic        take;
  logic        last;
  logic [24:0] ms_add;

  assign raw[0] = atom_x;
  assign raw[1] = atom_y;
  assign raw[2] = atom_z;
  assign box[0] = box_x;
  assign box[1] = box_y;
  assign box[2] = box_z;

  // Clamp of the molecule size.
  always_comb begin
    if (atoms_per_molecule == 8'd0) begin
      mol_size = 8'd1;
    end else if (atoms_per_molecule > 8'(mcom_pkg::MaxAtoms)) begin
      mol_size = 8'(mcom_pkg::MaxAtoms);
    end else begin
      mol_size = atoms_per_molecule;
    end
  end

  // The last stage stalls only when a finished molecule cannot leave.
  assign in_ready = !(mol_valid && !mol_ready);
  assign take = in_valid && in_ready;
  assign last = (atom_counter + 8'd1) >= mol_size;

  // Minimum-image fold per axis.
  always_comb begin
    logic signed [33:0] d;
    logic signed [33:0] b;
    for (int k = 0; k < 3; k++) begin
      d = 34'(signed'(raw[k])) - 34'(signed'(prev[k]));
      b = signed'({3'b000, box[k]});
      if ((d <<< 1) > b) begin
        d = d - b;
      end else if ((d <<< 1) < -b) begin
        d = d + b;
      end
      if (atom_counter == 8'd0) begin
        unw_next[k] = 40'(signed'(raw[k]));
      end else begin
        unw_next[k] = unw[k] + 40'(d);
      end
    end
  end

  assign ms_add = {1'b0, mass_sum} + {9'd0, atom_mass};

  // Unwrap state and the fold stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_counter <= '0;
      mass_sum <= '0;
      s1_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev[k] <= '0;
        unw[k] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid <= take;
      end
      if (take) begin
        for (int k = 0; k < 3; k++) begin
          prev[k] <= raw[k];
          unw[k] <= unw_next[k];
          s1_pos[k] <= unw_next[k];
        end
        s1_mass <= atom_mass;
        s1_last <= last;
        s1_first <= (atom_counter == 8'd0);
        s1_msum <= ms_add[24] ? 24'hFFFFFF : ms_add[23:0];
        if (last) begin
          atom_counter <= '0;
          mass_sum <= '0;
        end else begin
          atom_counter <= atom_counter + 8'd1;
          mass_sum <= ms_add[24] ? 24'hFFFFFF : ms_add[23:0];
        end
      end
    end
  end

  // Multiply-accumulate stage; emits a molecule on its last atom.
  always_ff @(posedge clk) begin
    logic [63:0] acc;
    logic signed [56:0] prod;
    if (rst) begin
      mol_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        wsum[k] <= '0;
      end
    end else begin
      if (mol_valid && mol_ready) begin
        mol_valid <= 1'b0;
      end
      if (s1_valid && in_ready) begin
        for (int k = 0; k < 3; k++) begin
          prod = signed'(s1_pos[k]) * signed'({1'b0, s1_mass});
          acc = (s1_first ? 64'd0 : wsum[k]) + 64'(prod);
          wsum[k] <= acc;
          if (s1_last) begin
            case (k)
              0: mol.sum_x <= acc;
              1: mol.sum_y <= acc;
              default: mol.sum_z <= acc;
            endcase
          end
        end
        if (s1_last) begin
          mol.mass <= s1_msum;
          mol_valid <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/mcom_queue.sv =====
// Short queue of finished molecules between front end and divider.
// Depends on mcom_pkg.
module mcom_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mcom_pkg::mol_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output mcom_pkg::mol_t rd_data
);
  mcom_pkg::mol_t slots [mcom_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign wr_ready = count != 2'(mcom_pkg::QueueDepth);
  assign rd_valid = count != 2'd0;
  assign rd_data = slots[rd_ptr];

  // Two-entry circular buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr <= !wr_ptr;
      end
      if (rd_valid && rd_ready) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ===== rtl/mcom_divider.sv =====
// Back end: one-bit-per-cycle restoring divider for the three centers.
// Depends on mcom_pkg.
module mcom_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mcom_pkg::mol_t in_mol,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    center_x,
  output logic [31:0]    center_y,
  output logic [31:0]    center_z,
  output logic [22:0]    total_mass
);
  mcom_pkg::div_state_t state, state_next;
  logic [63:0] mag [3];
  logic [63:0] quo [3];
  logic [24:0] rem [3];
  logic        neg [3];
  logic [23:0] div;
  logic [5:0]  bit_cnt;
  logic [31:0] res [3];

  assign in_ready = state == mcom_pkg::DIV_IDLE;
  assign out_valid = state == mcom_pkg::DIV_DONE;
  assign center_x = res[0];
  assign center_y = res[1];
  assign center_z = res[2];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mcom_pkg::DIV_IDLE: if (in_valid) state_next = mcom_pkg::DIV_RUN;
      mcom_pkg::DIV_RUN:  if (bit_cnt == 6'd0) state_next = mcom_pkg::DIV_DONE;
      mcom_pkg::DIV_DONE: if (out_ready) state_next = mcom_pkg::DIV_IDLE;
      default:            state_next = mcom_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcom_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: load magnitudes, shift one quotient bit per cycle, then round.
  always_ff @(posedge clk) begin
    logic [63:0] s;
    logic [24:0] r;
    logic [63:0] q;
    logic [25:0] r2;
    case (state)
      mcom_pkg::DIV_IDLE: begin
        if (in_valid) begin
          for (int k = 0; k < 3; k++) begin
            case (k)
              0: s = in_mol.sum_x;
              1: s = in_mol.sum_y;
              default: s = in_mol.sum_z;
            endcase
            neg[k] <= s[63];
            mag[k] <= s[63] ? (~s + 64'd1) : s;
            rem[k] <= '0;
            quo[k] <= '0;
          end
          div <= in_mol.mass;
          total_mass <= (in_mol.mass > 24'h7FFFFF) ? 23'h7FFFFF : in_mol.mass[22:0];
          bit_cnt <= 6'd63;
        end
      end
      mcom_pkg::DIV_RUN: begin
        for (int k = 0; k < 3; k++) begin
          r = {rem[k][23:0], mag[k][63]};
          q = {quo[k][62:0], 1'b0};
          if (r >= {1'b0, div}) begin
            r = r - {1'b0, div};
            q[0] = 1'b1;
          end
          rem[k] <= r;
          quo[k] <= q;
          mag[k] <= {mag[k][62:0], 1'b0};
          if (bit_cnt == 6'd0) begin
            // Round half away from zero, then saturate.
            r2 = {r, 1'b0};
            if (r2 >= {2'b00, div}) q = q + 64'd1;
            if (div == 24'd0) begin
              res[k] <= '0;
            end else if (neg[k]) begin
              res[k] <= (q > 64'h80000000) ? 32'h80000000 : 32'(~q + 64'd1);
            end else begin
              res[k] <= (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            end
          end
        end
        bit_cnt <= bit_cnt - 6'd1;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/molecule_center_of_mass_pbc_core.sv =====
// Molecule center of mass core. One atom a cycle enters the front end
// while it is not stalled; the front end unwraps it across the periodic
// box and accumulates mass-weighted positions; each finished molecule
// passes through a two-entry queue to a bit-serial divider that works out
// 64 quotient bits after a load and before the hand-off, and that takes no
// new molecule until its result is taken. Molecules with few atoms are
// limited by the divider and stall the input once the queue is full.
// Depends on mcom_pkg, mcom_front, mcom_queue, mcom_divider and the assert header.
`include "molecule_center_of_mass_pbc_core_assert.svh"
module molecule_center_of_mass_pbc_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // atom_x[31:0], atom_y[63:32], atom_z[95:64], atom_mass[111:96]
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], total_mass[118:96]
  output logic [119:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  logic [30:0] box_x, box_y, box_z;
  logic [7:0]  atoms;
  logic        cfg_we;
  logic        mol_valid, mol_ready, q_valid, q_ready;
  mcom_pkg::mol_t mol, q_mol;
  logic [31:0] cx, cy, cz;
  logic [22:0] tm;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= 31'd65536;
      box_y <= 31'd65536;
      box_z <= 31'd65536;
      atoms <= 8'd3;
    end else if (cfg_we) begin
      case (mcom_pkg::reg_idx_t'(paddr[3:2]))
        mcom_pkg::REG_BOX_X: box_x <= pwdata[30:0];
        mcom_pkg::REG_BOX_Y: box_y <= pwdata[30:0];
        mcom_pkg::REG_BOX_Z: box_z <= pwdata[30:0];
        mcom_pkg::REG_ATOMS: atoms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (mcom_pkg::reg_idx_t'(paddr[3:2]))
      mcom_pkg::REG_BOX_X: prdata = {1'b0, box_x};
      mcom_pkg::REG_BOX_Y: prdata = {1'b0, box_y};
      mcom_pkg::REG_BOX_Z: prdata = {1'b0, box_z};
      mcom_pkg::REG_ATOMS: prdata = {24'd0, atoms};
      default:             prdata = '0;
    endcase
  end

  mcom_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .atom_x(s_tdata[31:0]), .atom_y(s_tdata[63:32]),
    .atom_z(s_tdata[95:64]), .atom_mass(s_tdata[111:96]),
    .box_x(box_x), .box_y(box_y), .box_z(box_z),
    .atoms_per_molecule(atoms),
    .mol_valid(mol_valid), .mol_ready(mol_ready), .mol(mol)
  );

  mcom_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(mol_valid), .wr_ready(mol_ready), .wr_data(mol),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_mol)
  );

  mcom_divider u_div (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_mol(q_mol),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .center_x(cx), .center_y(cy), .center_z(cz), .total_mass(tm)
  );

  assign m_tdata = {1'b0, tm, cz, cy, cx};

  // A held result stays put until it is taken.
  `MCOM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // When the divider takes a molecule from the queue, no result is pending at its output.
  `MCOM_ASSERT_IMPL(a_div_load, clk, rst, q_ready && q_valid, !m_tvalid)
endmodule

// ===== test/molecule_center_of_mass_pbc_core_checker.sv =====
// Checker for the molecule center of mass core: watches the atom, result and
// register channels, predicts each molecule's result and compares it.
// Depends on mcom_pkg for the register indexes.
module molecule_center_of_mass_pbc_core_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending,
  output int           atoms_seen,
  output int           molecules_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [22:0] mass;
  } center_t;

  center_t centers_due[$];

  // Shadow of the registers and of the accumulator state.
  logic [30:0]        box_len[3];
  logic [7:0]         mol_size_reg;
  logic [31:0]        last_raw[3];
  logic signed [39:0] unwrapped[3];
  logic [63:0]        moment_sum[3];
  logic [23:0]        mass_acc;
  int                 atom_idx;

  assign pending = centers_due.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in molecule %0d: %s got %h expected %h", molecules_seen, what, got, want);
    fail_count++;
  endtask

  // Q40.24 sum over Q16.8 mass, rounded half away from zero, saturated.
  function automatic logic [31:0] divide_center(logic [63:0] s, logic [23:0] m);
    longint unsigned mag, q, r, mm;
    mm = m;
    if (m == 0) return 32'd0;
    mag = s[63] ? -s : s;
    q = mag / mm;
    r = mag % mm;
    if (r >= mm - r) q++;
    if (s[63]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      q = -q;
      return q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic clear_molecule();
    for (int k = 0; k < 3; k++) begin
      last_raw[k] = '0;
      unwrapped[k] = '0;
      moment_sum[k] = '0;
    end
    mass_acc = '0;
    atom_idx = 0;
  endtask

  // Fold, unwrap and accumulate one atom; close the molecule when full.
  task automatic take_atom(input logic [111:0] d);
    longint mass, raw, diff, b;
    int unsigned ms;
    int size;
    center_t c;
    mass = d[111:96];
    for (int k = 0; k < 3; k++) begin
      raw = longint'($signed(d[32*k +: 32]));
      if (atom_idx == 0) begin
        unwrapped[k] = raw[39:0];
      end else begin
        diff = raw - longint'($signed(last_raw[k]));
        b = box_len[k];
        if (2 * diff > b) diff = diff - b;
        else if (2 * diff < -b) diff = diff + b;
        unwrapped[k] = unwrapped[k] + diff[39:0];
      end
      last_raw[k] = d[32*k +: 32];
      moment_sum[k] = moment_sum[k] + longint'(unwrapped[k]) * mass;
    end
    ms = mass_acc + int'(mass);
    mass_acc = (ms > 24'hFF_FFFF) ? 24'hFF_FFFF : ms[23:0];
    atom_idx++;
    size = (mol_size_reg == 0) ? 1 :
           (mol_size_reg > mcom_pkg::MaxAtoms) ? mcom_pkg::MaxAtoms : mol_size_reg;
    if (atom_idx >= size) begin
      c.cx = divide_center(moment_sum[0], mass_acc);
      c.cy = divide_center(moment_sum[1], mass_acc);
      c.cz = divide_center(moment_sum[2], mass_acc);
      c.mass = (mass_acc > 24'h7F_FFFF) ? 23'h7F_FFFF : mass_acc[22:0];
      centers_due.push_back(c);
      clear_molecule();
    end
  endtask

  initial begin
    fail_count = 0;
    atoms_seen = 0;
    molecules_seen = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      box_len[0] <= 31'd65536;
      box_len[1] <= 31'd65536;
      box_len[2] <= 31'd65536;
      mol_size_reg <= 8'd3;
      clear_molecule();
      centers_due.delete();
    end else begin
      // The bench must write registers only while no atom is moving; the core does not enforce it.
      if (psel && penable && pwrite && pready) begin
        case (mcom_pkg::reg_idx_t'(paddr[3:2]))
          mcom_pkg::REG_BOX_X: box_len[0] = pwdata[30:0];
          mcom_pkg::REG_BOX_Y: box_len[1] = pwdata[30:0];
          mcom_pkg::REG_BOX_Z: box_len[2] = pwdata[30:0];
          mcom_pkg::REG_ATOMS: mol_size_reg = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        take_atom(s_tdata);
        atoms_seen++;
      end
      if (m_tvalid && m_tready) begin
        center_t c;
        molecules_seen++;
        if (centers_due.size() == 0) begin
          report("unexpected result center_x", m_tdata[31:0], 32'd0);
        end else begin
          c = centers_due.pop_front();
          if (m_tdata[31:0] !== c.cx) report("center_x", m_tdata[31:0], c.cx);
          if (m_tdata[63:32] !== c.cy) report("center_y", m_tdata[63:32], c.cy);
          if (m_tdata[95:64] !== c.cz) report("center_z", m_tdata[95:64], c.cz);
          if (m_tdata[118:96] !== c.mass)
            report("total_mass", {9'd0, m_tdata[118:96]}, {9'd0, c.mass});
        end
      end
    end
  end
endmodule

// ===== test/molecule_center_of_mass_pbc_core_tb.sv =====
// Testbench top for the molecule center of mass core: drives atoms and
// register writes, stalls the result side, and gives the verdict.
// Depends on mcom_pkg, the core and molecule_center_of_mass_pbc_core_checker.
module molecule_center_of_mass_pbc_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 200;
  localparam int StallLimit = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // atom_x[31:0], atom_y[63:32], atom_z[95:64], atom_mass[111:96]
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // center_x[31:0], center_y[63:32], center_z[95:64], total_mass[118:96]
  logic [119:0] m_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int  fail_count, pending, atoms_seen, molecules_seen;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  all_sent = 1'b0;
  int  quiet_cycles = 0;
  int  phase_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  molecule_center_of_mass_pbc_core dut (.*);

  molecule_center_of_mass_pbc_core_checker u_checker (.*);

  function automatic logic [111:0] atom(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [15:0] m);
    return {m, z, y, x};
  endfunction

  task automatic reg_write(input mcom_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one word and hold it until taken, then maybe leave a gap.
  task automatic send_atom(input logic [111:0] d);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Let outstanding molecules drain before touching the registers.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_mass();
    case ($urandom_range(0, 9))
      0: return 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Mostly molecules whose atoms sit close together, some crossing the box
  // edge; the rest is unrelated positions.
  task automatic send_molecules(input int n, input logic [31:0] box[3]);
    logic [31:0] pos[3];
    bit coherent;
    int left;
    left = 0;
    coherent = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 8);
        coherent = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < 3; k++) pos[k] = $urandom;
      end
      for (int k = 0; k < 3; k++) begin
        if (!coherent) begin
          pos[k] = $urandom;
        end else begin
          pos[k] = pos[k] + $signed(32'($urandom_range(0, 4096))) - 32'sd2048;
          case ($urandom_range(0, 5))
            0: pos[k] = pos[k] + box[k];
            1: pos[k] = pos[k] - box[k];
            2: pos[k] = pos[k] + (box[k] >> 1) + 32'($urandom_range(0, 2)) - 32'd1;
            default: ;
          endcase
        end
      end
      left--;
      if (all_sent == 0 && i >= n - 150 && phase_count >= 9) no_idle = 1'b1;
      send_atom(atom(pos[0], pos[1], pos[2], pick_mass()));
    end
  endtask

  // Result side: random ready and stall bursts, a long hold-off on request.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout: no traffic for %0d cycles", StallLimit);
      $display("** molecule_center_of_mass_pbc_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0] box[3];
    int size, n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed atoms under the reset box of 1.0 and three atoms a molecule.
    send_atom(atom(32'h0, 32'h0, 32'h0, 16'd1));
    send_atom(atom(32'h8001, 32'hFFFF_7FFF, 32'h8000, 16'd1));
    send_atom(atom(32'h0, 32'h0, 32'hFFFF_8000, 16'hFFFF));
    send_atom(atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
    send_atom(atom(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF));
    send_atom(atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
    send_atom(atom(32'hFFFF_FFFF, 32'h1, 32'h0, 16'd1));
    send_atom(atom(32'h1, 32'hFFFF_FFFF, 32'h0, 16'd2));
    send_atom(atom(32'h0, 32'h0, 32'h0, 16'd1));
    send_atom(atom(32'h7FFF_0000, 32'h8001_0000, 32'h1234_5678, 16'h8000));
    send_atom(atom(32'h7FFF_8000, 32'h8000_8000, 32'h1234_D678, 16'h0100));
    send_atom(atom(32'h7FFF_FFFF, 32'h8000_0000, 32'h1235_5678, 16'h00FF));
    for (int i = 0; i < 12; i++)
      send_atom(atom($urandom, $urandom, $urandom, pick_mass()));
    phase_count++;

    // Phases with changing box and molecule size, extremes first.
    for (int p = 0; p < 10; p++) begin
      settle();
      case (p)
        0: begin box = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; size = 1; end
        1: begin box = '{32'd1, 32'd1, 32'd1}; size = 128; end
        2: begin box = '{32'h10000, 32'h7FFF_FFFF, 32'd1}; size = 0; end
        3: begin box = '{32'($urandom_range(1, 32'h7FFF_FFFF)), 32'h20000, 32'h80000};
                 size = 255; end
        default: begin
          for (int k = 0; k < 3; k++)
            box[k] = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 32'h7FFF_FFFF))
                                                 : 32'($urandom_range(1, 32'h100000));
          size = $urandom_range(1, 9);
        end
      endcase
      reg_write(mcom_pkg::REG_BOX_X, box[0]);
      reg_write(mcom_pkg::REG_BOX_Y, box[1]);
      reg_write(mcom_pkg::REG_BOX_Z, box[2]);
      reg_write(mcom_pkg::REG_ATOMS, 32'(size));
      // The divider is slowest with single atoms, so fill it up here.
      if (p == 0) hold_req = 1'b1;
      n = (size == 0 || size == 1) ? 80 : (size >= 128) ? 260 : 90;
      send_molecules(n, box);
      phase_count++;
    end

    all_sent = 1'b1;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d atoms in %0d phases, %0d molecules checked, register settings varied",
             atoms_seen, phase_count, molecules_seen);
    if (fail_count == 0) begin
      $display("** molecule_center_of_mass_pbc_core: PASSED **");
    end else begin
      $display("** molecule_center_of_mass_pbc_core: FAILED **");
    end
    $finish;
  end
endmodule
